// ===== rtl/csv_field_tokenizer_unit_defines.svh =====
// Assertion macros for the CSV field tokenizer.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef CSV_FIELD_TOKENIZER_UNIT_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CSVT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvt check failed");
// next-cycle implication
`define CSVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvt check failed");
`else
`define CSVT_ASSERT_NOW(label, ante, cons)
`define CSVT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/csvt_pkg.sv =====
// Shared types and constants for the CSV field tokenizer.
// No dependencies; used by csvt_step, csvt_out_queue and the top level.
package csvt_pkg;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } csvt_kind_t;

    localparam logic [0:0] REG_DELIMITER = 1'b0;
    localparam logic [0:0] REG_QUOTE     = 1'b1;

    localparam logic [7:0] DELIMITER_RESET = 8'd44;  // ','
    localparam logic [7:0] QUOTE_RESET     = 8'd34;  // '"'
    localparam logic [7:0] NEWLINE_BYTE    = 8'd10;

    typedef struct packed {
        logic at_field_start;
        logic in_quotes;
        logic quote_pending;
    } csvt_flags_t;

    typedef struct packed {
        csvt_kind_t kind;
        logic [7:0] data;
        logic [7:0] index;
        logic       last;
    } csvt_result_t;

endpackage

// ===== rtl/csvt_step.sv =====
// Per-byte tokenizer step: next state and up to two results for one item.
// Depends on csvt_pkg.
module csvt_step
    import csvt_pkg::*;
#(
    parameter int FIELD_INDEX_BITS = 8
)
(
    input  logic [7:0]                  in_byte,
    input  logic                        line_end,
    input  logic [7:0]                  delimiter_char,
    input  logic [7:0]                  quote_char,
    input  csvt_flags_t                 flags,
    input  logic [FIELD_INDEX_BITS-1:0] field_count,
    output csvt_flags_t                 flags_next,
    output logic [FIELD_INDEX_BITS-1:0] field_count_next,
    output logic [1:0]                  num_results,
    output csvt_result_t                res0,
    output csvt_result_t                res1
);

    logic [FIELD_INDEX_BITS+7:0]  count_ext;
    logic [7:0]                   cur_index;
    logic                         is_delim;
    logic                         is_quote;
    logic [FIELD_INDEX_BITS-1:0]  count_adv;

    assign count_ext = {8'd0, field_count};
    assign cur_index = count_ext[7:0];
    assign is_delim  = (in_byte == delimiter_char);
    assign is_quote  = (in_byte == quote_char);
    // saturating advance to the next field
    assign count_adv = (field_count == '1) ? field_count
                                           : field_count + FIELD_INDEX_BITS'(1);

    always_comb
    begin
        flags_next       = flags;
        field_count_next = field_count;
        num_results      = 2'd0;
        res0             = '{kind: KIND_DATA, data: 8'd0, index: cur_index, last: 1'b0};
        res1             = '{kind: KIND_DATA, data: 8'd0, index: cur_index, last: 1'b1};

        priority if (line_end)
        begin
            if (flags.in_quotes && !flags.quote_pending)
            begin
                num_results               = 2'd1;
                res0.data                 = NEWLINE_BYTE;
                flags_next.at_field_start = 1'b0;
            end
            else
            begin
                num_results      = 2'd2;
                res0.kind        = KIND_FIELD_END;
                res1.kind        = KIND_ROW_END;
                flags_next       = '{at_field_start: 1'b1, in_quotes: 1'b0,
                                     quote_pending: 1'b0};
                field_count_next = '0;
            end
        end
        else if (!flags.in_quotes)
        begin
            priority if (is_delim)
            begin
                num_results      = 2'd1;
                res0.kind        = KIND_FIELD_END;
                flags_next       = '{at_field_start: 1'b1, in_quotes: 1'b0,
                                     quote_pending: 1'b0};
                field_count_next = count_adv;
            end
            else if (is_quote && flags.at_field_start)
            begin
                flags_next.in_quotes      = 1'b1;
                flags_next.at_field_start = 1'b0;
            end
            else
            begin
                num_results               = 2'd1;
                res0.data                 = in_byte;
                flags_next.at_field_start = 1'b0;
            end
        end
        else if (flags.quote_pending)
        begin
            priority if (is_delim)
            begin
                num_results      = 2'd1;
                res0.kind        = KIND_FIELD_END;
                flags_next       = '{at_field_start: 1'b1, in_quotes: 1'b0,
                                     quote_pending: 1'b0};
                field_count_next = count_adv;
            end
            else if (is_quote)
            begin
                // doubled quote: one literal quote
                num_results              = 2'd1;
                res0.data                = quote_char;
                flags_next.quote_pending = 1'b0;
            end
            else
            begin
                // release the held quote, then the byte itself
                num_results              = 2'd2;
                res0.data                = quote_char;
                res1.data                = in_byte;
                flags_next.quote_pending = 1'b0;
            end
        end
        else
        begin
            if (is_quote)
            begin
                flags_next.quote_pending = 1'b1;
            end
            else
            begin
                num_results = 2'd1;
                res0.data   = in_byte;
            end
        end

        res0.last = (num_results == 2'd1);
    end

endmodule

// ===== rtl/csvt_out_queue.sv =====
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on csvt_pkg.
module csvt_out_queue
    import csvt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   push_num,
    input  csvt_result_t push0,
    input  csvt_result_t push1,
    input  logic         pop,
    output logic         has_room,
    output logic         not_empty,
    output csvt_result_t head,
    output logic [2:0]   level
);

    csvt_result_t entry_reg [4];
    logic [1:0]   wr_ptr_reg;
    logic [1:0]   wr_ptr_next;
    logic [1:0]   rd_ptr_reg;
    logic [1:0]   rd_ptr_next;
    logic [2:0]   count_reg;
    logic [2:0]   count_next;
    logic         do_pop;

    assign not_empty = (count_reg != 3'd0);
    assign has_room  = (count_reg <= 3'd2);  // room for a two-result item
    assign head      = entry_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign do_pop    = pop && not_empty;

    assign wr_ptr_next = wr_ptr_reg + push_num;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
    assign count_next  = count_reg + {1'b0, push_num} - {2'b00, do_pop};

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_num == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/csv_field_tokenizer_unit.sv =====
// Top level of the CSV field tokenizer: config registers, parser state, result queue.
// Depends on csvt_pkg, csvt_step, csvt_out_queue and csv_field_tokenizer_unit_defines.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  input   | in_valid / in_ready  | in_byte, line_end
//  output  | out_valid / out_ready| kind, out_byte, field_index, last
//  config  | cfg_wen              | cfg_index, cfg_data
//
// One item per cycle while in_ready is high: the parser state updates in the cycle of
// the input transfer and its results are registered in a four-entry queue for the output.
// Items with two results leave through the single output port one result at a time.
// in_ready drops while the queue holds three or more results; it never looks at out_ready.
// Reset clears the parser state to the start of the first field and empties the queue.
`include "csv_field_tokenizer_unit_defines.svh"

module csv_field_tokenizer_unit
    import csvt_pkg::*;
#(
    parameter int FIELD_INDEX_BITS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [7:0] field_index,
    output logic       last
);

    logic [7:0]                  delimiter_reg;
    logic [7:0]                  quote_reg;
    csvt_flags_t                 flags_reg;
    csvt_flags_t                 flags_next;
    logic [FIELD_INDEX_BITS-1:0] field_count_reg;
    logic [FIELD_INDEX_BITS-1:0] field_count_next;
    logic [1:0]                  num_results;
    csvt_result_t                res0;
    csvt_result_t                res1;
    csvt_result_t                head;
    logic                        in_fire;
    logic [2:0]                  q_level;

    assign in_fire = in_valid && in_ready;

    csvt_step #(
        .FIELD_INDEX_BITS(FIELD_INDEX_BITS)
    ) u_step (
        .in_byte         (in_byte),
        .line_end        (line_end),
        .delimiter_char  (delimiter_reg),
        .quote_char      (quote_reg),
        .flags           (flags_reg),
        .field_count     (field_count_reg),
        .flags_next      (flags_next),
        .field_count_next(field_count_next),
        .num_results     (num_results),
        .res0            (res0),
        .res1            (res1)
    );

    csvt_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_num (in_fire ? num_results : 2'd0),
        .push0    (res0),
        .push1    (res1),
        .pop      (out_ready),
        .has_room (in_ready),
        .not_empty(out_valid),
        .head     (head),
        .level    (q_level)
    );

    assign kind        = head.kind;
    assign out_byte    = head.data;
    assign field_index = head.index;
    assign last        = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIMITER_RESET;
            quote_reg     <= QUOTE_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_DELIMITER: delimiter_reg <= cfg_data;
                REG_QUOTE:     quote_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg       <= '{at_field_start: 1'b1, in_quotes: 1'b0, quote_pending: 1'b0};
            field_count_reg <= '0;
        end
        else if (in_fire)
        begin
            flags_reg       <= flags_next;
            field_count_reg <= field_count_next;
        end
    end

    // a held quote only exists inside a quoted field
    `CSVT_ASSERT_NOW(a_pending_quoted, flags_reg.quote_pending, flags_reg.in_quotes)
    // queue never overfills
    `CSVT_ASSERT_NOW(a_queue_bound, 1'b1, q_level <= 3'd4)
    // a line end outside quotes restarts the row
    `CSVT_ASSERT_NEXT(a_row_restart, in_fire && line_end && !flags_reg.in_quotes,
                      field_count_reg == '0 && flags_reg.at_field_start)
    // a transfer of a line end outside quotes yields two results
    `CSVT_ASSERT_NOW(a_row_two, in_fire && line_end && !flags_reg.in_quotes,
                     num_results == 2'd2)

endmodule

// ===== test/csv_field_tokenizer_checker.sv =====
// Scoreboard for csv_field_tokenizer_unit: tracks the parser state from input transfers
// and register writes, and checks each output transfer against the oldest prediction.
// Depends on csvt_pkg.
module csv_field_tokenizer_checker
    import csvt_pkg::*;
#(
    parameter int FIELD_INDEX_BITS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       line_end,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] kind,
    input  logic [7:0] out_byte,
    input  logic [7:0] field_index,
    input  logic       last,
    output int         tokens_pending,
    output int         mismatch_count
);

    localparam int INDEX_MAX = (1 << FIELD_INDEX_BITS) - 1;

    logic [7:0]   delimiter;
    logic [7:0]   quote;
    logic         at_start;
    logic         quoted;
    logic         held_quote;
    int           field_num;
    int           mismatches = 0;
    csvt_result_t expected_tokens[$];
    csvt_result_t oldest;

    // field index is taken before the state moves on
    function automatic void emit(csvt_kind_t k, logic [7:0] d);
        csvt_result_t t;
        t.kind  = k;
        t.data  = d;
        t.index = field_num[7:0];
        t.last  = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void start_field(bit new_row);
        if (new_row)
            field_num = 0;
        else if (field_num < INDEX_MAX)
            field_num++;
        at_start   = 1'b1;
        quoted     = 1'b0;
        held_quote = 1'b0;
    endfunction

    function automatic void tokenize(logic [7:0] b, logic eol);
        int           prior;
        int           tail;
        csvt_result_t t;
        prior = expected_tokens.size();
        if (eol)
        begin
            if (quoted && !held_quote)
            begin
                emit(KIND_DATA, NEWLINE_BYTE);
                at_start = 1'b0;
            end
            else
            begin
                emit(KIND_FIELD_END, 8'h00);
                emit(KIND_ROW_END, 8'h00);
                start_field(1'b1);
            end
        end
        else if (!quoted)
        begin
            if (b == delimiter)
            begin
                emit(KIND_FIELD_END, 8'h00);
                start_field(1'b0);
            end
            else if (b == quote && at_start)
            begin
                quoted   = 1'b1;
                at_start = 1'b0;
            end
            else
            begin
                emit(KIND_DATA, b);
                at_start = 1'b0;
            end
        end
        else if (held_quote)
        begin
            // delimiter wins over quote when both bytes are equal
            if (b == delimiter)
            begin
                emit(KIND_FIELD_END, 8'h00);
                start_field(1'b0);
            end
            else if (b == quote)
            begin
                emit(KIND_DATA, quote);
                held_quote = 1'b0;
            end
            else
            begin
                emit(KIND_DATA, quote);
                emit(KIND_DATA, b);
                held_quote = 1'b0;
            end
        end
        else if (b == quote)
            held_quote = 1'b1;
        else
            emit(KIND_DATA, b);

        if (expected_tokens.size() > prior)
        begin
            tail = expected_tokens.size() - 1;
            t = expected_tokens[tail];
            t.last = 1'b1;
            expected_tokens[tail] = t;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter = DELIMITER_RESET;
            quote     = QUOTE_RESET;
            start_field(1'b1);
            expected_tokens.delete();
            tokens_pending <= 0;
            mismatch_count <= mismatches;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transfer: kind %0d byte %02h index %0d last %0b",
                                 kind, out_byte, field_index, last);
                end
                else
                begin
                    oldest = expected_tokens.pop_front();
                    if (oldest.kind !== kind || oldest.data !== out_byte ||
                        oldest.index !== field_index || oldest.last !== last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"output mismatch: expected kind %0d byte %02h index %0d ",
                                      "last %0b, got kind %0d byte %02h index %0d last %0b"},
                                     oldest.kind, oldest.data, oldest.index, oldest.last,
                                     kind, out_byte, field_index, last);
                    end
                end
            end
            if (in_valid && in_ready)
                tokenize(in_byte, line_end);
            if (cfg_wen)
            begin
                if (cfg_index == REG_DELIMITER)
                    delimiter = cfg_data;
                else if (cfg_index == REG_QUOTE)
                    quote = cfg_data;
            end
            tokens_pending <= expected_tokens.size();
            mismatch_count <= mismatches;
        end
    end

endmodule

// ===== test/tb_csv_field_tokenizer_unit.sv =====
// Testbench top for csv_field_tokenizer_unit: clock, reset, register writes, directed and
// random CSV traffic with random idling on both channels, and the final verdict.
// Depends on csvt_pkg, the block's RTL and csv_field_tokenizer_checker.
module tb_csv_field_tokenizer_unit;
    import csvt_pkg::*;

    localparam int FIELD_INDEX_BITS = 8;
    localparam int SETTLE_CYCLES    = 4;
    localparam int CYCLE_LIMIT      = 400000;

    logic       clk;
    logic       rst_n;
    logic       cfg_wen;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       line_end;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] field_index;
    logic       last;

    int         tokens_pending;
    int         mismatch_count;
    int         cycle_count;
    int         items_sent;
    bit         tx_no_idle;
    bit         rx_no_idle;
    logic [7:0] delim_now;
    logic [7:0] quote_now;

    csv_field_tokenizer_unit #(
        .FIELD_INDEX_BITS(FIELD_INDEX_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .out_byte   (out_byte),
        .field_index(field_index),
        .last       (last)
    );

    csv_field_tokenizer_checker #(
        .FIELD_INDEX_BITS(FIELD_INDEX_BITS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .line_end      (line_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .out_byte      (out_byte),
        .field_index   (field_index),
        .last          (last),
        .tokens_pending(tokens_pending),
        .mismatch_count(mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_csv_field_tokenizer_unit: errors");
        $finish;
    end

    // receiver: random stall before each output transfer, with stall-free stretches
    initial
    begin
        int stall;
        int served;
        out_ready  = 1'b0;
        rx_no_idle = 1'b0;
        served     = 0;
        forever
        begin
            if (served % 48 == 0)
                rx_no_idle = ($urandom_range(0, 3) == 0);
            stall = rx_no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            served++;
        end
    end

    // line_end items carry a random byte that the block must ignore
    task automatic send(input logic [7:0] b, input logic eol);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= eol ? 8'($urandom) : b;
        line_end <= eol;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tokens_pending != 0);
        // a quote that opens a field or is held leaves nothing to wait for
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] d, input logic [7:0] q);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_DELIMITER;
        cfg_data  <= d;
        @(posedge clk);
        cfg_index <= REG_QUOTE;
        cfg_data  <= q;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        delim_now = d;
        quote_now = q;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == delim_now || b == quote_now);
        return b;
    endfunction

    // mostly well-formed rows with random content, some noise in between
    task automatic run_phase(input int count, input bit long_row);
        int         stop_at;
        int         n_fields;
        int         n_chars;
        int         pick;
        logic [7:0] nb;
        stop_at = items_sent + count;
        if (long_row)
        begin
            // enough delimiters to push the field index into saturation
            tx_no_idle = 1'b1;
            repeat ($urandom_range(256, 300)) send(delim_now, 1'b0);
            send(8'h00, 1'b1);
        end
        while (items_sent < stop_at)
        begin
            tx_no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 24) == 0)
                wait_idle();
            if ($urandom_range(0, 4) != 0)
            begin
                n_fields = $urandom_range(1, 4);
                for (int f = 0; f < n_fields; f++)
                begin
                    n_chars = $urandom_range(0, 5);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        send(quote_now, 1'b0);
                        repeat (n_chars)
                        begin
                            pick = $urandom_range(0, 9);
                            if (pick < 2)
                            begin
                                send(quote_now, 1'b0);
                                send(quote_now, 1'b0);
                            end
                            else if (pick == 2)
                                send(8'h00, 1'b1);
                            else
                                send(plain_byte(), 1'b0);
                        end
                        send(quote_now, 1'b0);
                    end
                    else
                    begin
                        repeat (n_chars)
                        begin
                            nb = ($urandom_range(0, 7) == 0) ? quote_now : plain_byte();
                            send(nb, 1'b0);
                        end
                    end
                    if (f < n_fields - 1)
                        send(delim_now, 1'b0);
                end
                send(8'h00, 1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3)
                        nb = delim_now;
                    else if (pick < 6)
                        nb = quote_now;
                    else
                        nb = 8'($urandom);
                    send(nb, pick == 6);
                end
            end
        end
    endtask

    initial
    begin
        logic [7:0] rnd_delim;
        logic [7:0] rnd_quote;
        rst_n      = 1'b0;
        cfg_wen    = 1'b0;
        cfg_index  = REG_DELIMITER;
        cfg_data   = 8'h00;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        line_end   = 1'b0;
        items_sent = 0;
        tx_no_idle = 1'b0;
        delim_now  = DELIMITER_RESET;
        quote_now  = QUOTE_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset values of the registers
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        send(delim_now, 1'b0);
        send(quote_now, 1'b0);          // opens quoted field
        send("a", 1'b0);
        send(8'h00, 1'b1);              // line end inside quotes -> newline byte
        send(quote_now, 1'b0);
        send(quote_now, 1'b0);          // doubled quote -> one quote
        send(quote_now, 1'b0);
        send("b", 1'b0);                // releases held quote, then itself
        send(quote_now, 1'b0);
        send(delim_now, 1'b0);          // held quote closes the field
        send("x", 1'b0);
        send(quote_now, 1'b0);          // quote mid-field is plain content
        send(delim_now, 1'b0);
        send(quote_now, 1'b0);
        send(quote_now, 1'b0);
        send(8'h00, 1'b1);              // line end with a held quote
        send(8'h00, 1'b1);              // empty row
        wait_idle();

        run_phase(400, 1'b1);
        wait_idle();
        configure(8'h7C, 8'h7C);        // delimiter and quote share a byte
        run_phase(300, 1'b0);
        wait_idle();
        configure(8'h00, 8'hFF);
        run_phase(300, 1'b0);
        wait_idle();
        configure(8'hFF, 8'h00);
        run_phase(300, 1'b0);
        wait_idle();
        rnd_delim = 8'($urandom);
        rnd_quote = ($urandom_range(0, 3) == 0) ? rnd_delim : 8'($urandom);
        configure(rnd_delim, rnd_quote);
        run_phase(300, 1'b0);

        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_csv_field_tokenizer_unit: clean");
        else
            $display("tb_csv_field_tokenizer_unit: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/csvt_pkg.sv
rtl/csvt_step.sv
rtl/csvt_out_queue.sv
rtl/csv_field_tokenizer_unit.sv
test/csv_field_tokenizer_checker.sv
test/tb_csv_field_tokenizer_unit.sv
